// ===== src/isfd_pkg.sv =====
// Shared types and constants for the index stream field decoder.
package isfd_pkg;

  localparam int KindW = 3;
  localparam int ValueW = 64;
  localparam int CountW = 4;
  localparam int ShiftW = 6;

  localparam logic [KindW-1:0] KIND_SHORT = 3'd0;
  localparam logic [KindW-1:0] KIND_INT   = 3'd1;
  localparam logic [KindW-1:0] KIND_LONG  = 3'd2;
  localparam logic [KindW-1:0] KIND_VINT  = 3'd3;
  localparam logic [KindW-1:0] KIND_VLONG = 3'd4;

  localparam logic [7:0] GROUP_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  localparam logic [CountW-1:0] SHORT_BYTES     = 4'd2;
  localparam logic [CountW-1:0] INT_BYTES       = 4'd4;
  localparam logic [CountW-1:0] LONG_BYTES      = 4'd8;
  localparam logic [CountW-1:0] VINT_MAX_BYTES  = 4'd5;
  localparam logic [CountW-1:0] VLONG_MAX_BYTES = 4'd10;
  localparam logic [CountW-1:0] VAR_MAX_TAKEN   = 4'd9;

  // Decoder state carried between bytes.
  typedef struct packed {
    logic [ValueW-1:0] accumulator;
    logic [CountW-1:0] bytes_taken;
    logic [KindW-1:0]  field_type;
    logic              in_field;
  } state_t;

  // One decoded field.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [KindW-1:0]  kind;
    logic              overlong;
  } result_t;

endpackage

// ===== src/isfd_step.sv =====
// Per-byte field decode: next state and optional result from current state and one byte.
module isfd_step (
  input  isfd_pkg::state_t  state,
  input  logic [7:0]        byte_in,
  input  logic [2:0]        kind,
  output isfd_pkg::state_t  state_next,
  output isfd_pkg::result_t result
);
  import isfd_pkg::*;

  logic              start;
  logic              drop;
  logic [KindW-1:0]  ftype;
  logic [ValueW-1:0] acc0;
  logic [CountW-1:0] cnt0;
  logic [CountW-1:0] cnt1;
  logic [ValueW-1:0] acc1;
  logic [ValueW-1:0] group;
  logic [6:0]        shift_full;
  logic [ShiftW-1:0] shamt;
  logic [CountW-1:0] need;
  logic              done;
  logic              err;

  assign start = !state.in_field;
  assign drop  = start && (kind > KIND_VLONG);
  assign ftype = start ? kind : state.field_type;
  assign acc0  = start ? '0 : state.accumulator;
  assign cnt0  = start ? '0 : state.bytes_taken;
  assign cnt1  = cnt0 + 4'd1;

  // 7 bits per group, least significant group first.
  assign shift_full = 7'(cnt0) * 7'd7;
  assign shamt      = shift_full[ShiftW-1:0];
  assign group      = ValueW'(byte_in & GROUP_MASK);

  always_comb begin
    unique case (ftype)
      KIND_SHORT: need = SHORT_BYTES;
      KIND_INT:   need = INT_BYTES;
      KIND_LONG:  need = LONG_BYTES;
      KIND_VINT:  need = VINT_MAX_BYTES;
      default:    need = VLONG_MAX_BYTES;
    endcase
  end

  always_comb begin
    acc1 = '0;
    done = 1'b0;
    err  = 1'b0;
    if (ftype <= KIND_LONG) begin
      // Big-endian: shift the new byte in at the bottom.
      acc1 = {acc0[ValueW-9:0], byte_in};
      done = (cnt1 >= need);
    end else begin
      acc1 = acc0 | (group << shamt);
      if (ftype == KIND_VINT) begin
        acc1[ValueW-1:32] = '0;
      end
      if ((byte_in & CONT_BIT) == 8'h00) begin
        done = 1'b1;
      end else if (cnt1 >= need) begin
        done = 1'b1;
        err  = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    if (!drop) begin
      state_next.field_type = ftype;
      if (done) begin
        state_next.in_field    = 1'b0;
        state_next.accumulator = '0;
        state_next.bytes_taken = '0;
        result.valid    = 1'b1;
        result.value    = acc1;
        result.kind     = ftype;
        result.overlong = err;
      end else begin
        state_next.in_field    = 1'b1;
        state_next.accumulator = acc1;
        state_next.bytes_taken = cnt1;
      end
    end
  end

endmodule

// ===== src/index_stream_field_decoder.sv =====
// Top level of the byte-serial short/int/long/vint/vlong field decoder.
//
// Usage:
//   Feed one stream byte per transaction on the s_axis channel: tdata carries
//   the byte, tuser carries the field kind (0 short, 1 int, 2 long, 3 vint,
//   4 vlong). The kind is sampled only on the first byte of a field; a first
//   byte with an unused kind (5..7) is dropped and the decoder stays idle.
//   Fixed kinds are big-endian and end after 2, 4 or 8 bytes. Variable kinds
//   take 7 bits per byte, low group first, and end at a byte with bit 7 clear,
//   or at the 5th (vint) / 10th (vlong) byte with overlong set.
//   At each field end one transaction leaves on m_axis: tdata is the value
//   zero-extended to 64 bits, tuser holds the kind and the overlong flag.
// Timing:
//   A byte is held in an input register, decoded by one pass of short logic
//   and its result lands in the output register, from which it leaves once
//   the receiver is ready. One byte per cycle is sustained while the
//   receiver keeps up; the single decode pass bounds the rate.
// Reset and stall:
//   rst (synchronous) clears the field state and both valid flags. When the
//   receiver stalls, the pending result holds and the input register fills;
//   s_axis_tready then drops until the output register drains.
module index_stream_field_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [3:0]  m_axis_tuser    // [2:0] kind_out, [3] overlong
);
  import isfd_pkg::*;

  // Input register.
  logic             in_valid;
  logic [7:0]       in_byte;
  logic [KindW-1:0] in_kind;

  // Field state.
  state_t state;
  state_t state_next;
  result_t result;

  // Output register.
  logic              out_valid;
  logic [ValueW-1:0] out_value;
  logic [KindW-1:0]  out_kind;
  logic              out_overlong;

  logic advance;
  logic in_take;

  // Decode the held byte when the output register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  isfd_step u_step (
    .state      (state),
    .byte_in    (in_byte),
    .kind       (in_kind),
    .state_next (state_next),
    .result     (result)
  );

  // Capture incoming bytes; drop the valid flag once the byte is decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= s_axis_tdata;
      in_kind <= s_axis_tuser;
    end
  end

  // Advance the field state one byte at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Load a finished field, or clear once the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_value    <= result.value;
      out_kind     <= result.kind;
      out_overlong <= result.overlong;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = {out_overlong, out_kind};

  // Idle between fields means a clean accumulator and count.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !state.in_field |-> (state.accumulator == '0 && state.bytes_taken == '0))
    else $error("idle decoder holds stale field data");

  // A field never keeps more than nine bytes pending.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state.bytes_taken <= VAR_MAX_TAKEN)
    else $error("byte count past variable field limit");

  // A vint in progress never sets bits above 31.
  a_vint_width: assert property (@(posedge clk) disable iff (rst)
    (state.in_field && state.field_type == KIND_VINT) |->
      state.accumulator[ValueW-1:32] == '0)
    else $error("vint accumulator wider than 32 bits");

  // Overlong is only reported for variable kinds.
  a_overlong_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_overlong) |-> (out_kind == KIND_VINT || out_kind == KIND_VLONG))
    else $error("overlong flag on a fixed-width field");

  // A result never appears without a decoded byte behind it.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a decode step");

endmodule
